/* rtl/core/mdda_pkg.sv */
// Shared constants and interface structs for the multi-axis DDA step generator.
// Used by the divider, the square-root unit and the top level; depends on nothing.
package mdda_pkg;

    // Build-time configuration of the block.
    localparam int NUM_AXES          = 4;
    localparam int OVERSAMPLE_FACTOR = 4;

    // Axis ports that exist on the top level.
    localparam int NAX    = 4;
    localparam int CNT_W  = 20;
    localparam int DIV_W  = 37;
    localparam int DIV_Q  = 32;
    localparam int SQ_W   = 64;
    localparam int ROOT_W = 31;

    localparam logic [CNT_W-1:0] CNT_MAX   = '1;
    localparam logic [NAX-1:0]   AX_ACTIVE = NAX'((1 << NUM_AXES) - 1);
    localparam logic [1:0]       AX_LAST   = 2'(NUM_AXES - 1);

    // Error accumulator constants in signed Q4.28.
    localparam logic signed [33:0] FX_HALF  = 34'sd134217728;
    localparam logic signed [33:0] FX_ONE   = 34'sd268435456;
    localparam logic signed [33:0] LOOK_THR =
        34'(134217728 - 268435456 / OVERSAMPLE_FACTOR);

    // Divider request and response.
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] hi;
        logic [DIV_Q-1:0] lo;
        logic [DIV_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_Q-1:0] quot;
        logic             rem_nz;
    } t_div_rsp;

    // Square-root request and response.
    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] radicand;
    } t_sqrt_req;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_sqrt_rsp;

endpackage

/* rtl/core/mdda_div.sv */
// Restoring divider producing a 32-bit quotient, one quotient bit per cycle.
// Depends on mdda_pkg for widths and the request/response structs.
module mdda_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mdda_pkg::t_div_req i_req,
    output mdda_pkg::t_div_rsp o_rsp
);
    import mdda_pkg::*;

    localparam int CW = $clog2(DIV_Q);
    localparam logic [CW-1:0] LAST = CW'(DIV_Q - 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_den;
    logic [DIV_Q-1:0] r_quo;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             fits;

    // Shift the next dividend bit into the partial remainder and try the divisor.
    always_comb begin
        trial = {r_rem, r_quo[DIV_Q-1]};
        diff  = trial - {1'b0, r_den};
        fits  = (trial >= {1'b0, r_den});
    end

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Remainder and quotient registers; the quotient replaces the low dividend bits.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.hi;
            r_quo <= i_req.lo;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            r_quo <= {r_quo[DIV_Q-2:0], fits};
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.quot   = r_quo;
    assign o_rsp.rem_nz = |r_rem;

endmodule

/* rtl/core/mdda_sqrt.sv */
// Integer square root by the bit-pair method, one result bit per cycle.
// Depends on mdda_pkg for widths and the request/response structs.
module mdda_sqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mdda_pkg::t_sqrt_req i_req,
    output mdda_pkg::t_sqrt_rsp o_rsp
);
    import mdda_pkg::*;

    logic            r_busy;
    logic            r_done;
    logic [SQ_W-1:0] r_v;
    logic [SQ_W-1:0] r_res;
    logic [SQ_W-1:0] r_bit;
    logic [SQ_W-1:0] trial;
    logic            take;

    always_comb begin
        trial = r_res + r_bit;
        take  = (r_v >= trial);
    end

    // Run until the test bit has walked down to bit zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            if (r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Radicand, partial root and test bit.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_v   <= i_req.radicand;
            r_res <= '0;
            r_bit <= {2'b01, {(SQ_W-2){1'b0}}};
        end else if (r_busy) begin
            if (take) begin
                r_v   <= r_v - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_res[ROOT_W-1:0];

endmodule

/* rtl/core/multi_axis_dda_step_generator.sv */
// Top level of the multi-axis DDA step generator: sequencer, axis state and multiplier.
// Depends on mdda_pkg, mdda_div and mdda_sqrt.
//
// Usage: one input channel and one output channel, both valid/ready. Every input
// transaction yields exactly one output transaction. Mode 0 starts a move from the
// start and end positions; mode 1 requests the next step pulse set.
// The block works on one transaction at a time; o_in_ready is high only while the
// sequencer is idle. All division goes through one divider and the move
// length through one square-root unit. A start transaction is shorter when the
// move has no motion; a step transaction uses the divider once for each axis
// that still has steps, and a step after the move has finished uses neither unit.
// The result sits in an output register; the next transaction may be accepted
// while it waits, and the sequencer holds its next result until the register
// is free, so a stalled receiver stalls the block without losing anything.
// After reset no move is active: a step request returns move_done with an empty
// step mask and a zero direction mask.
module multi_axis_dda_step_generator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_mode,
    input  logic signed [31:0] i_start_axis0,
    input  logic signed [31:0] i_start_axis1,
    input  logic signed [31:0] i_start_axis2,
    input  logic signed [31:0] i_start_axis3,
    input  logic signed [31:0] i_end_axis0,
    input  logic signed [31:0] i_end_axis1,
    input  logic signed [31:0] i_end_axis2,
    input  logic signed [31:0] i_end_axis3,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [3:0]         o_step_mask,
    output logic [3:0]         o_dir_bits,
    output logic [31:0]        o_length_advance,
    output logic               o_move_done
);
    import mdda_pkg::*;

    localparam logic [4:0] ST_IDLE      = 5'd0;
    localparam logic [4:0] ST_MAX       = 5'd1;
    localparam logic [4:0] ST_INC_GO    = 5'd2;
    localparam logic [4:0] ST_INC_WAIT  = 5'd3;
    localparam logic [4:0] ST_MUL       = 5'd4;
    localparam logic [4:0] ST_ACC       = 5'd5;
    localparam logic [4:0] ST_SQRT_GO   = 5'd6;
    localparam logic [4:0] ST_SQRT_WAIT = 5'd7;
    localparam logic [4:0] ST_UNIT_GO   = 5'd8;
    localparam logic [4:0] ST_UNIT_WAIT = 5'd9;
    localparam logic [4:0] ST_K_GO      = 5'd10;
    localparam logic [4:0] ST_K_WAIT    = 5'd11;
    localparam logic [4:0] ST_KMUL      = 5'd12;
    localparam logic [4:0] ST_KAPP      = 5'd13;
    localparam logic [4:0] ST_LOOK      = 5'd14;
    localparam logic [4:0] ST_LEN       = 5'd15;
    localparam logic [4:0] ST_OUT       = 5'd16;

    logic [4:0] r_state;
    logic [4:0] n_state;

    // Per-axis state.
    logic [CNT_W-1:0]   r_rem  [NAX];
    logic signed [31:0] r_err  [NAX];
    logic [28:0]        r_inc  [NAX];
    logic [30:0]        r_unit [NAX];
    logic [32:0]        r_dist [NAX];
    logic [NAX-1:0]     r_dir;
    logic [39:0]        r_prev;
    logic               r_fin;

    // Sequencer working registers.
    logic [DIV_W-1:0]   r_den;
    logic [ROOT_W-1:0]  r_len;
    logic [1:0]         r_ax;
    logic [31:0]        r_k;
    logic               r_any;
    logic [NAX-1:0]     r_steps;
    logic               r_is_start;
    logic               r_mul_len;
    logic [59:0]        r_prod;
    logic [53:0]        r_acc;
    logic [31:0]        r_res_adv;
    logic               r_res_done;

    // Output register.
    logic               r_out_valid;
    logic [NAX-1:0]     r_out_step;
    logic [NAX-1:0]     r_out_dir;
    logic [31:0]        r_out_adv;
    logic               r_out_done;

    logic in_fire;
    logic out_free;
    logic ax_last;

    t_div_req  div_req;
    t_div_rsp  div_rsp;
    t_sqrt_req sqrt_req;
    t_sqrt_rsp sqrt_rsp;

    mdda_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    mdda_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sqrt_req),
        .o_rsp   (sqrt_rsp)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign ax_last    = (r_ax == AX_LAST);

    // Round a Q19.12 position half away from zero to a whole step.
    function automatic logic signed [21:0] round_q12(input logic signed [31:0] x);
        logic [32:0]        mag;
        logic [20:0]        q;
        logic signed [21:0] sq;
        mag = x[31] ? (33'd0 - {x[31], x}) : {1'b0, x};
        q   = 21'((mag + 33'd2048) >> 12);
        sq  = $signed({1'b0, q});
        return x[31] ? -sq : sq;
    endfunction

    // Start transaction: step counts, residues and distances for every axis.
    logic signed [31:0] in_s [NAX];
    logic signed [31:0] in_e [NAX];
    logic [CNT_W-1:0]   prep_rem  [NAX];
    logic signed [31:0] prep_err  [NAX];
    logic [32:0]        prep_dist [NAX];
    logic [NAX-1:0]     prep_dir;

    assign in_s[0] = i_start_axis0;
    assign in_s[1] = i_start_axis1;
    assign in_s[2] = i_start_axis2;
    assign in_s[3] = i_start_axis3;
    assign in_e[0] = i_end_axis0;
    assign in_e[1] = i_end_axis1;
    assign in_e[2] = i_end_axis2;
    assign in_e[3] = i_end_axis3;

    always_comb begin
        logic signed [21:0] qs;
        logic signed [21:0] qe;
        logic signed [21:0] tgt;
        logic [21:0]        tmag;
        logic signed [33:0] fr_full;
        logic signed [13:0] fr;
        logic signed [32:0] dd;
        for (int i = 0; i < NAX; i++) begin
            qs      = round_q12(in_s[i]);
            qe      = round_q12(in_e[i]);
            tgt     = qe - qs;
            tmag    = tgt[21] ? 22'(-tgt) : 22'(tgt);
            fr_full = $signed({{2{in_s[i][31]}}, in_s[i]})
                      - ($signed({{12{qs[21]}}, qs}) <<< 12);
            dd      = $signed({in_e[i][31], in_e[i]}) - $signed({in_s[i][31], in_s[i]});
            fr      = dd[32] ? -fr_full[13:0] : fr_full[13:0];
            prep_rem[i]  = '0;
            prep_err[i]  = '0;
            prep_dist[i] = '0;
            prep_dir[i]  = 1'b0;
            if (AX_ACTIVE[i]) begin
                prep_rem[i]  = (tmag > 22'(CNT_MAX)) ? CNT_MAX : tmag[CNT_W-1:0];
                prep_err[i]  = {{2{fr[13]}}, fr, 16'd0};
                prep_dist[i] = dd[32] ? 33'(-dd) : 33'(dd);
                prep_dir[i]  = dd[32];
            end
        end
    end

    // Largest distance and the increment divisor.
    logic [32:0]      max01;
    logic [32:0]      max23;
    logic [32:0]      max_dist;
    always_comb begin
        max01    = (r_dist[0] > r_dist[1]) ? r_dist[0] : r_dist[1];
        max23    = (r_dist[2] > r_dist[3]) ? r_dist[2] : r_dist[3];
        max_dist = (max01 > max23) ? max01 : max23;
    end

    // Gap to the wrap point for the current axis, clamped at zero.
    logic signed [33:0] gap;
    logic [31:0]        k_gap;
    logic               k_elig;
    logic [31:0]        k_i;
    always_comb begin
        gap    = FX_HALF - $signed({{2{r_err[r_ax][31]}}, r_err[r_ax]});
        k_gap  = gap[33] ? 32'd0 : gap[31:0];
        k_elig = (r_rem[r_ax] != '0) && (r_inc[r_ax] != '0);
        k_i    = div_rsp.quot + 32'd1;
    end

    // Divider requests from the sequencer.
    always_comb begin
        div_req = '0;
        unique case (r_state)
            ST_INC_GO: begin
                div_req.start = 1'b1;
                div_req.hi    = DIV_W'(r_dist[r_ax] >> 4);
                div_req.lo    = {r_dist[r_ax][3:0], 28'd0};
                div_req.den   = r_den;
            end
            ST_UNIT_GO: begin
                div_req.start = 1'b1;
                div_req.hi    = DIV_W'({r_rem[r_ax], 8'd0});
                div_req.den   = DIV_W'(r_len);
            end
            ST_K_GO: begin
                div_req.start = k_elig;
                div_req.lo    = k_gap;
                div_req.den   = DIV_W'(r_inc[r_ax]);
            end
            default: ;
        endcase
    end

    assign sqrt_req.start    = (r_state == ST_SQRT_GO);
    assign sqrt_req.radicand = SQ_W'({r_acc[41:0], 20'd0});

    // Shared multiplier: squares, length terms, and k times increment.
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    always_comb begin
        if (r_state == ST_KMUL) begin
            mul_a = r_k;
            mul_b = 32'(r_inc[r_ax]);
        end else begin
            mul_a = r_mul_len ? 32'(r_unit[r_ax]) : 32'(r_rem[r_ax]);
            mul_b = 32'(r_rem[r_ax]);
        end
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    // Apply k additions to the current axis and wrap into (-0.5, 0.5].
    logic signed [61:0] kx;
    logic [27:0]        km;
    logic               kwrap;
    logic signed [31:0] kapp_err;
    always_comb begin
        kx    = $signed({{30{r_err[r_ax][31]}}, r_err[r_ax]}) + $signed({2'b00, r_prod});
        km    = kx[27:0];
        kwrap = (kx > 62'sd134217728);
        if (kwrap) begin
            kapp_err = (km > 28'd134217728) ? {4'hF, km} : {4'h0, km};
        end else begin
            kapp_err = kx[31:0];
        end
    end

    // Lookahead: take any step that one more increment brings within 1/OVERSAMPLE_FACTOR of wrapping.
    logic signed [31:0] look_err  [NAX];
    logic [NAX-1:0]     look_wrap;
    always_comb begin
        logic signed [33:0] lx;
        for (int i = 0; i < NAX; i++) begin
            lx           = $signed({{2{r_err[i][31]}}, r_err[i]}) + $signed({5'd0, r_inc[i]});
            look_wrap[i] = AX_ACTIVE[i] && (lx > LOOK_THR);
            look_err[i]  = look_wrap[i] ? 32'(lx - FX_ONE) : (AX_ACTIVE[i] ? lx[31:0] : r_err[i]);
        end
    end

    // Length along the move and the advance since the last result.
    logic [39:0] len_now;
    logic [39:0] len_diff;
    logic [31:0] len_adv;
    always_comb begin
        len_now  = r_acc[53:14];
        len_diff = r_prev - len_now;
        if (r_prev > len_now) begin
            len_adv = (|len_diff[39:32]) ? 32'hFFFF_FFFF : len_diff[31:0];
        end else begin
            len_adv = 32'd0;
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (!i_mode) n_state = ST_MAX;
                    else if (r_fin) n_state = ST_OUT;
                    else n_state = ST_K_GO;
                end
            end
            ST_MAX:       n_state = (max_dist == '0) ? ST_MUL : ST_INC_GO;
            ST_INC_GO:    n_state = ST_INC_WAIT;
            ST_INC_WAIT: begin
                if (div_rsp.done) n_state = ax_last ? ST_MUL : ST_INC_GO;
            end
            ST_MUL:       n_state = ST_ACC;
            ST_ACC: begin
                if (ax_last) n_state = r_mul_len ? ST_LEN : ST_SQRT_GO;
                else n_state = ST_MUL;
            end
            ST_SQRT_GO:   n_state = ST_SQRT_WAIT;
            ST_SQRT_WAIT: begin
                if (sqrt_rsp.done) n_state = (sqrt_rsp.root == '0) ? ST_MUL : ST_UNIT_GO;
            end
            ST_UNIT_GO:   n_state = ST_UNIT_WAIT;
            ST_UNIT_WAIT: begin
                if (div_rsp.done) n_state = ax_last ? ST_MUL : ST_UNIT_GO;
            end
            ST_K_GO: begin
                if (k_elig) n_state = ST_K_WAIT;
                else if (ax_last) n_state = ST_KMUL;
            end
            ST_K_WAIT: begin
                if (div_rsp.done) n_state = ax_last ? ST_KMUL : ST_K_GO;
            end
            ST_KMUL:      n_state = ST_KAPP;
            ST_KAPP:      n_state = ax_last ? ST_LOOK : ST_KMUL;
            ST_LOOK:      n_state = ST_MUL;
            ST_LEN:       n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) n_state = ST_IDLE;
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fin       <= 1'b1;
            r_dir       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_fire && !i_mode) begin
                r_fin <= 1'b0;
                r_dir <= prep_dir;
            end else if (r_state == ST_LOOK) begin
                r_fin <= (r_steps == '0);
            end
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_ax       <= '0;
                r_any      <= 1'b0;
                r_k        <= 32'd1;
                r_steps    <= '0;
                r_res_adv  <= '0;
                r_res_done <= 1'b1;
                r_is_start <= !i_mode;
                if (in_fire && !i_mode) begin
                    for (int i = 0; i < NAX; i++) begin
                        r_rem[i]  <= prep_rem[i];
                        r_err[i]  <= prep_err[i];
                        r_dist[i] <= prep_dist[i];
                        r_inc[i]  <= '0;
                        r_unit[i] <= '0;
                    end
                end
            end
            ST_MAX: begin
                r_den     <= DIV_W'(max_dist) * DIV_W'(OVERSAMPLE_FACTOR);
                r_ax      <= '0;
                r_acc     <= '0;
                r_mul_len <= 1'b0;
            end
            ST_INC_WAIT: begin
                if (div_rsp.done) begin
                    r_inc[r_ax] <= 29'(div_rsp.quot + 32'(div_rsp.rem_nz));
                    r_ax        <= ax_last ? 2'd0 : r_ax + 1'b1;
                    if (ax_last) begin
                        r_acc     <= '0;
                        r_mul_len <= 1'b0;
                    end
                end
            end
            ST_MUL, ST_KMUL: begin
                r_prod <= mul_p[59:0];
            end
            ST_ACC: begin
                r_acc <= r_acc + r_prod[53:0];
                r_ax  <= ax_last ? 2'd0 : r_ax + 1'b1;
            end
            ST_SQRT_WAIT: begin
                if (sqrt_rsp.done) begin
                    r_len <= sqrt_rsp.root;
                    r_ax  <= '0;
                    if (sqrt_rsp.root == '0) begin
                        r_acc     <= '0;
                        r_mul_len <= 1'b1;
                    end
                end
            end
            ST_UNIT_WAIT: begin
                if (div_rsp.done) begin
                    r_unit[r_ax] <= div_rsp.quot[30:0];
                    r_ax         <= ax_last ? 2'd0 : r_ax + 1'b1;
                    r_acc        <= '0;
                    r_mul_len    <= 1'b1;
                end
            end
            ST_K_GO: begin
                if (!k_elig) begin
                    r_ax <= ax_last ? 2'd0 : r_ax + 1'b1;
                    if (ax_last && !r_any) r_k <= 32'd1;
                end
            end
            ST_K_WAIT: begin
                if (div_rsp.done) begin
                    if (!r_any || (k_i < r_k)) r_k <= k_i;
                    r_any <= 1'b1;
                    r_ax  <= ax_last ? 2'd0 : r_ax + 1'b1;
                end
            end
            ST_KAPP: begin
                r_err[r_ax] <= kapp_err;
                if (kwrap && (r_rem[r_ax] != '0)) begin
                    r_steps[r_ax] <= 1'b1;
                    r_rem[r_ax]   <= r_rem[r_ax] - 1'b1;
                end
                r_ax <= ax_last ? 2'd0 : r_ax + 1'b1;
            end
            ST_LOOK: begin
                for (int i = 0; i < NAX; i++) begin
                    r_err[i] <= look_err[i];
                    if (look_wrap[i] && (r_rem[i] != '0)) begin
                        r_steps[i] <= 1'b1;
                        r_rem[i]   <= r_rem[i] - 1'b1;
                    end
                end
                r_ax      <= '0;
                r_acc     <= '0;
                r_mul_len <= 1'b1;
            end
            ST_LEN: begin
                r_prev <= len_now;
                if (r_is_start) begin
                    r_res_adv  <= '0;
                    r_res_done <= 1'b0;
                end else begin
                    r_res_adv  <= len_adv;
                    r_res_done <= (r_steps == '0);
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    r_out_step <= r_steps;
                    r_out_dir  <= r_dir;
                    r_out_adv  <= r_res_adv;
                    r_out_done <= r_res_done;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_step_mask      = r_out_step;
    assign o_dir_bits       = r_out_dir;
    assign o_length_advance = r_out_adv;
    assign o_move_done      = r_out_done;

endmodule

/* tb/tb_multi_axis_dda_step_generator.sv */
// Self-checking testbench for the multi-axis DDA step generator.
// Depends on mdda_pkg and the multi_axis_dda_step_generator RTL.
`timescale 1ns / 1ps

module tb_multi_axis_dda_step_generator;
    import mdda_pkg::*;

    localparam int LIMIT_CYCLES = 4000000;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam longint HALF_Q = 64'sd134217728;
    localparam longint ONE_Q  = 64'sd268435456;

    typedef struct packed {
        logic [3:0]  step_mask;
        logic [3:0]  dir_bits;
        logic [31:0] length_advance;
        logic        move_done;
    } t_motion_rsp;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_mode = 1'b0;
    logic signed [31:0] i_start_axis0 = '0, i_start_axis1 = '0;
    logic signed [31:0] i_start_axis2 = '0, i_start_axis3 = '0;
    logic signed [31:0] i_end_axis0 = '0, i_end_axis1 = '0;
    logic signed [31:0] i_end_axis2 = '0, i_end_axis3 = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [3:0]         o_step_mask;
    logic [3:0]         o_dir_bits;
    logic [31:0]        o_length_advance;
    logic               o_move_done;

    // Predictor state, a private copy of the block's move state.
    logic [19:0]  pred_count [4];
    longint       pred_err [4];
    longint       pred_inc [4];
    longint       pred_unit [4];
    longint       pred_prev_len;
    bit           pred_finished;
    logic [3:0]   pred_dir;

    t_motion_rsp  expected_rsp_q [$];
    int           error_count = 0;
    int           rsp_count = 0;
    int           item_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_off_cycles = 0;
    bit           hold_off_req = 1'b0;
    bit           hold_off_seen = 1'b0;
    longint       cycle_count = 0;

    multi_axis_dda_step_generator DUT (.*);

    // Clock generation.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Cycle counter with a generous limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout at %0t", $time);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic longint round_half_away(longint x);
        if (x >= 0) return (x + 2048) / 4096;
        return -((-x + 2048) / 4096);
    endfunction

    function automatic longint int_sqrt(logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    function automatic longint move_length();
        logic [63:0] acc;
        acc = 0;
        for (int i = 0; i < NUM_AXES; i++)
            acc += 64'(pred_unit[i]) * 64'(pred_count[i]);
        return longint'((acc >> 14) & 64'hFF_FFFF_FFFF);
    endfunction

    // Start of a move: quantize, seed accumulators, scale increments, unit vector.
    function automatic void predict_start(logic signed [31:0] s[4], logic signed [31:0] e[4]);
        longint span_abs [4];
        longint maxd, qs, tgt, frac, d, mag, qlen;
        logic [63:0] sumsq, den, num;
        maxd = 0;
        sumsq = 0;
        pred_dir = 0;
        for (int i = 0; i < 4; i++) begin
            pred_count[i] = 0; pred_err[i] = 0; pred_inc[i] = 0; pred_unit[i] = 0;
            span_abs[i] = 0;
        end
        for (int i = 0; i < NUM_AXES; i++) begin
            qs = round_half_away(longint'(s[i]));
            tgt = round_half_away(longint'(e[i])) - qs;
            frac = longint'(s[i]) - qs * 4096;
            d = longint'(e[i]) - longint'(s[i]);
            mag = tgt < 0 ? -tgt : tgt;
            pred_count[i] = mag > 64'hFFFFF ? 20'hFFFFF : 20'(mag);
            if (d < 0) begin
                d = -d;
                pred_dir[i] = 1'b1;
                frac = -frac;
            end
            pred_err[i] = longint'(signed'(32'(frac * 65536)));
            span_abs[i] = d;
            if (d > maxd) maxd = d;
        end
        if (maxd != 0) begin
            den = 64'(maxd) * OVERSAMPLE_FACTOR;
            for (int i = 0; i < NUM_AXES; i++) begin
                num = 64'(span_abs[i]) << 28;
                pred_inc[i] = longint'(32'((num + den - 1) / den));
            end
        end
        for (int i = 0; i < NUM_AXES; i++)
            sumsq += 64'(pred_count[i]) * 64'(pred_count[i]);
        qlen = int_sqrt(sumsq << 20);
        if (qlen != 0)
            for (int i = 0; i < NUM_AXES; i++)
                pred_unit[i] = longint'(32'((64'(pred_count[i]) << 40) / 64'(qlen)));
        pred_prev_len = move_length();
        pred_finished = 1'b0;
    endfunction

    // One step request: closed-form search, lookahead, length update.
    function automatic t_motion_rsp predict_step();
        t_motion_rsp r;
        longint k, ki, gap, x, w, thr, now, adv;
        bit found;
        logic [3:0] steps;
        steps = 0; adv = 0; k = 0; found = 0;
        thr = HALF_Q - ONE_Q / OVERSAMPLE_FACTOR;
        r.dir_bits = pred_dir;
        if (pred_finished) begin
            r.step_mask = 0; r.length_advance = 0; r.move_done = 1;
            return r;
        end
        for (int i = 0; i < NUM_AXES; i++) begin
            if (pred_count[i] != 0 && pred_inc[i] != 0) begin
                gap = HALF_Q - pred_err[i];
                ki = (gap < 0 ? 0 : gap / pred_inc[i]) + 1;
                if (!found || ki < k) k = ki;
                found = 1;
            end
        end
        if (!found) k = 1;
        for (int i = 0; i < NUM_AXES; i++) begin
            x = pred_err[i] + k * pred_inc[i];
            if (x > HALF_Q) begin
                w = (x - HALF_Q - 1) / ONE_Q + 1;
                x -= w * ONE_Q;
                if (pred_count[i] != 0) begin
                    steps[i] = 1'b1;
                    pred_count[i]--;
                end
            end
            pred_err[i] = longint'(signed'(32'(x)));
        end
        if (steps == 0) pred_finished = 1'b1;
        for (int i = 0; i < NUM_AXES; i++) begin
            x = pred_err[i] + pred_inc[i];
            if (x > thr) begin
                x -= ONE_Q;
                if (pred_count[i] != 0) begin
                    steps[i] = 1'b1;
                    pred_count[i]--;
                end
            end
            pred_err[i] = longint'(signed'(32'(x)));
        end
        now = move_length();
        if (pred_prev_len > now) begin
            adv = pred_prev_len - now;
            if (adv > 64'hFFFF_FFFF) adv = 64'hFFFF_FFFF;
        end
        pred_prev_len = now;
        r.step_mask = steps;
        r.length_advance = 32'(adv);
        r.move_done = (steps == 0);
        return r;
    endfunction

    // Send one transaction, predict its result once it is accepted.
    // Valid stays high between back-to-back transactions and drops only while idling.
    task automatic send_item(bit mode, logic signed [31:0] s[4], logic signed [31:0] e[4]);
        t_motion_rsp r;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_start_axis0 <= s[0]; i_start_axis1 <= s[1];
        i_start_axis2 <= s[2]; i_start_axis3 <= s[3];
        i_end_axis0 <= e[0]; i_end_axis1 <= e[1];
        i_end_axis2 <= e[2]; i_end_axis3 <= e[3];
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (mode == 1'b0) begin
            predict_start(s, e);
            r.step_mask = 0; r.dir_bits = pred_dir; r.length_advance = 0; r.move_done = 0;
        end else begin
            r = predict_step();
        end
        expected_rsp_q.push_back(r);
        item_count++;
    endtask

    task automatic send_step();
        logic signed [31:0] z[4];
        for (int i = 0; i < 4; i++) z[i] = $urandom;
        send_item(1'b1, z, z);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Random move with small distances so that moves finish in a few dozen steps.
    task automatic send_random_move(int span);
        logic signed [31:0] s[4], e[4];
        for (int i = 0; i < 4; i++) begin
            s[i] = $signed($urandom);
            if ($urandom_range(3) == 0) s[i] = $signed($urandom_range(8191)) - 4096;
            e[i] = s[i] + $signed($urandom_range(2 * span)) - span;
            if ($urandom_range(7) == 0) e[i] = s[i];
        end
        send_item(1'b0, s, e);
    endtask

    // Receiver: random stalls plus a long hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_off_req != hold_off_seen) begin
            hold_off_seen <= hold_off_req;
            hold_off_cycles <= HOLD_OFF_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_motion_rsp got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_step_mask, o_dir_bits, o_length_advance, o_move_done};
            rsp_count++;
            if (expected_rsp_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                error_count++;
            end else begin
                want = expected_rsp_q.pop_front();
                if (got.step_mask !== want.step_mask) begin
                    $display("%0t: step_mask exp %h got %h", $time, want.step_mask, got.step_mask);
                    error_count++;
                end
                if (got.dir_bits !== want.dir_bits) begin
                    $display("%0t: dir_bits exp %h got %h", $time, want.dir_bits, got.dir_bits);
                    error_count++;
                end
                if (got.length_advance !== want.length_advance) begin
                    $display("%0t: length_advance exp %h got %h", $time,
                             want.length_advance, got.length_advance);
                    error_count++;
                end
                if (got.move_done !== want.move_done) begin
                    $display("%0t: move_done exp %b got %b", $time, want.move_done, got.move_done);
                    error_count++;
                end
            end
        end
    end

    // Directed corner cases: idle steps, extremes, zero motion, saturation.
    task automatic test_directed();
        logic signed [31:0] s[4], e[4];
        send_step();
        for (int i = 0; i < 4; i++) begin s[i] = 32'sh8000_0000; e[i] = 32'sh7FFF_FFFF; end
        send_item(1'b0, s, e);
        repeat (3) send_step();
        for (int i = 0; i < 4; i++) begin s[i] = 32'sh7FFF_FFFF; e[i] = 32'sh8000_0000; end
        send_item(1'b0, s, e);
        send_step();
        for (int i = 0; i < 4; i++) begin s[i] = 2048; e[i] = 2048; end
        send_item(1'b0, s, e);
        repeat (2) send_step();
        s = '{-2048, 2047, 0, 100};
        e = '{-2048 + 5 * 4096, 2047 - 3 * 4096, 1, 100 + 4096};
        send_item(1'b0, s, e);
        repeat (12) send_step();
    endtask

    // Random moves, each followed by 0 to 4 or 10 to 25 step requests, so some finish and others are aborted.
    task automatic test_random(int n_items);
        int target;
        target = item_count + n_items;
        while (item_count < target) begin
            send_random_move($urandom_range(3) == 0 ? 200000 : 40000);
            repeat ($urandom_range(4) == 0 ? $urandom_range(4) : $urandom_range(10, 25))
                send_step();
        end
    endtask

    // Long receiver hold-off while the sender keeps offering transactions.
    task automatic test_backpressure();
        hold_off_req = !hold_off_req;
        send_random_move(20000);
        repeat (6) send_step();
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        wait_drained();
        test_random(120);
        wait_drained();
        send_idle_pct = 88;
        test_random(120);
        wait_drained();
        send_idle_pct = 0; recv_stall_pct = 88;
        test_random(120);
        wait_drained();
        send_idle_pct = 32; recv_stall_pct = 32;
        test_random(120);
        wait_drained();
        send_idle_pct = 0; recv_stall_pct = 0;
        test_backpressure();
        wait_drained();
        repeat (400) @(posedge i_clk);
        $display("Covered %0d transactions and %0d results: start moves, steps, idle steps,",
                 item_count, rsp_count);
        $display("extreme positions, zero motion and back-pressure.");
        if (error_count == 0 && expected_rsp_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
